>>> rtl/twg_pkg.sv
// types, constants and the sine table for the table waveform generator
// no dependencies; imported by every rtl file of the block
package twg_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int TABLE_AW   = $clog2(TABLE_SIZE);
    localparam int FULL_SCALE = 4095;
    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_MAX = (FULL_SCALE > 4095) ? 4095 : FULL_SCALE;
    localparam int PHASE_W    = 8;
    localparam int GAIN_W     = 17;
    localparam int GAIN_FRAC  = 16;
    localparam int PERIOD_W   = 16;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int SCALED_W   = PROD_W - GAIN_FRAC;
    localparam int TRI_W      = TABLE_AW + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 17'd65536;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd999;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } t_wave;

    typedef logic [SAMPLE_W-1:0] t_sine_rom [TABLE_SIZE];

    // q30 fixed point constants for building the sine table
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TaylorDiv [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // sin of pi/2*a/TABLE_SIZE in q30, taylor series through x^17
    function automatic longint unsigned sin_q30(input longint unsigned a);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        if (a == 0) begin
            return 64'd0;
        end
        if (a >= TABLE_SIZE) begin
            return Q30_ONE;
        end
        x    = (HALF_PI_Q30 * a) / TABLE_SIZE;
        term = x;
        sum  = x;
        for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TaylorDiv[k];
            if (k % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        return (sum > Q30_ONE) ? Q30_ONE : sum;
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom       rom;
        longint unsigned n;
        longint unsigned p;
        longint unsigned a;
        longint unsigned s;
        longint unsigned num;
        logic            neg;
        n = TABLE_SIZE;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            p = 4 * longint'(i);
            if (p <= n) begin
                a = p;         neg = 1'b0;
            end else if (p <= 2 * n) begin
                a = 2 * n - p; neg = 1'b0;
            end else if (p <= 3 * n) begin
                a = p - 2 * n; neg = 1'b1;
            end else begin
                a = 4 * n - p; neg = 1'b1;
            end
            s      = sin_q30(a);
            num    = neg ? (Q30_ONE - s) : (Q30_ONE + s);
            rom[i] = SAMPLE_W'((longint'(FULL_SCALE) * num) >> 31);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

>>> rtl/twg_if.sv
// valid/ready channels of the table waveform generator: tick, sample, config
// depends on twg_pkg for the payload widths
interface twg_in_if;
    logic valid;
    logic ready;
    logic run;
    modport source (output valid, output run, input ready);
    modport sink   (input valid, input run, output ready);
endinterface

interface twg_out_if
    import twg_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [PHASE_W-1:0]  phase_index;
    logic                cycle_end;
    modport source (output valid, output sample, output phase_index, output cycle_end,
                    input ready);
    modport sink   (input valid, input sample, input phase_index, input cycle_end,
                    output ready);
endinterface

interface twg_cfg_if
    import twg_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/table_waveform_generator.sv
// table waveform generator: one tick per input transfer, one sample per timer wrap
// the tick transfer that wraps the timer loads stage 1; the sample then moves on to the output register
// throughput: one tick per cycle while the output is taken, set by the tick stage and the output register
// synchronous active-low reset: timer, table index, valids cleared; select 0,
// gain unity, period 999; sine table is constant logic, no fill after reset
// depends on twg_pkg and twg_if
module table_waveform_generator
    import twg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    twg_in_if.sink    i_in,
    twg_cfg_if.sink   i_cfg,
    twg_out_if.source o_out
);

    logic [1:0]          r_wave_sel;
    logic [GAIN_W-1:0]   r_gain;
    logic [PERIOD_W-1:0] r_period;

    logic [PERIOD_W-1:0] r_tick, n_tick;
    logic [TABLE_AW-1:0] r_index, n_index;

    logic                r_s1_valid;
    logic [TABLE_AW-1:0] r_s1_pos;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic [PHASE_W-1:0]  r_phase;
    logic                r_cycle_end;

    logic                out_free;
    logic                s1_free;
    logic                in_xfer;
    logic                emit;

    logic [SAMPLE_W-1:0] base;
    logic [TRI_W-1:0]    tri_diff;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    logic [SAMPLE_W-1:0] n_sample;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel <= WAVE_SINE;
            r_gain     <= GAIN_RESET;
            r_period   <= PERIOD_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WAVE_SEL: r_wave_sel <= i_cfg.data[1:0];
                CFG_GAIN:     r_gain     <= i_cfg.data[GAIN_W-1:0];
                CFG_PERIOD:   r_period   <= i_cfg.data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: each stage moves when the one after it is free
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_free    = !r_s1_valid || out_free;
    assign i_in.ready = s1_free;
    assign in_xfer    = i_in.valid && s1_free;
    assign emit       = in_xfer && i_in.run && (r_tick >= r_period);

    always_comb begin
        n_tick  = r_tick;
        n_index = r_index;
        if (in_xfer) begin
            if (!i_in.run) begin
                n_tick  = '0;
                n_index = '0;
            end else if (r_tick < r_period) begin
                n_tick = r_tick + 1'b1;
            end else begin
                n_tick  = '0;
                n_index = r_index + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_index     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tick  <= n_tick;
            r_index <= n_index;
            if (s1_free) begin
                r_s1_valid <= emit;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_pos <= r_index;
        end
        if (out_free) begin
            r_sample    <= n_sample;
            r_phase     <= PHASE_W'(r_s1_pos);
            r_cycle_end <= (r_s1_pos == TABLE_AW'(TABLE_SIZE - 1));
        end
    end

    // base shape at the table position, then gain and saturation
    always_comb begin
        if ({r_s1_pos, 1'b0} >= TRI_W'(TABLE_SIZE)) begin
            tri_diff = {r_s1_pos, 1'b0} - TRI_W'(TABLE_SIZE);
        end else begin
            tri_diff = TRI_W'(TABLE_SIZE) - {r_s1_pos, 1'b0};
        end
        case (t_wave'(r_wave_sel))
            WAVE_SINE:     base = SINE_ROM[r_s1_pos];
            WAVE_SQUARE:   base = (r_s1_pos < TABLE_AW'(TABLE_SIZE / 2)) ?
                                  SAMPLE_W'(FULL_SCALE) : '0;
            WAVE_TRIANGLE: base = SAMPLE_W'((32'(FULL_SCALE) * 32'(tri_diff)) >> TABLE_AW);
            WAVE_SAWTOOTH: base = SAMPLE_W'((32'(FULL_SCALE) * 32'(r_s1_pos)) >> TABLE_AW);
            default:       base = '0;
        endcase
        prod   = PROD_W'(base) * PROD_W'(r_gain);
        scaled = prod[PROD_W-1:GAIN_FRAC];
        if (scaled > SCALED_W'(SAMPLE_MAX)) begin
            n_sample = SAMPLE_W'(SAMPLE_MAX);
        end else begin
            n_sample = scaled[SAMPLE_W-1:0];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.sample      = r_sample;
    assign o_out.phase_index = r_phase;
    assign o_out.cycle_end   = r_cycle_end;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for table_waveform_generator: directed rows, then random phases of ticks
// samples checked vs. a timer/table model or typed rows; depends on twg_pkg, twg_if
module tb;
    import twg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint unsigned Q30_UNIT         = 64'd1073741824;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int TICK_TARGET = 1900;
    localparam int QUIET_FIRST = 6;
    localparam int QUIET_LAST  = 11;
    localparam int N_DIR       = 27;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  run;
        logic                  typed;
        logic [SAMPLE_W-1:0]   sample;
        logic [PHASE_W-1:0]    phase;
        logic                  cyc_end;
    } t_row;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [PHASE_W-1:0]  phase;
        logic                cyc_end;
    } t_sample_exp;

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row tick_row(logic run);
        t_row r;
        r      = '0;
        r.kind = ROW_TICK;
        r.run  = run;
        return r;
    endfunction

    function automatic t_row seen_row(logic [SAMPLE_W-1:0] sample, logic [PHASE_W-1:0] phase,
                                      logic cyc_end);
        t_row r;
        r         = tick_row(1'b1);
        r.typed   = 1'b1;
        r.sample  = sample;
        r.phase   = phase;
        r.cyc_end = cyc_end;
        return r;
    endfunction

    localparam t_row DIR_ROWS [N_DIR] = '{
        // reset period still in force: the timer only counts
        tick_row(1'b1), tick_row(1'b1), tick_row(1'b1),
        // period dropped below the count wraps at once
        cfg_row(CFG_PERIOD, 17'd0),
        seen_row(12'd2047, 8'd0, 1'b0),
        tick_row(1'b1),
        cfg_row(CFG_WAVE_SEL, CFG_DATA_W'(WAVE_SQUARE)),
        seen_row(12'd4095, 8'd2, 1'b0),
        cfg_row(CFG_GAIN, 17'd0),
        seen_row(12'd0, 8'd3, 1'b0),
        cfg_row(CFG_GAIN, 17'h1FFFF),
        seen_row(12'd4095, 8'd4, 1'b0),
        // upper data bits dropped: selects sawtooth
        cfg_row(CFG_WAVE_SEL, 17'h1FFFF),
        tick_row(1'b1),
        tick_row(1'b0),
        cfg_row(CFG_WAVE_SEL, CFG_DATA_W'(WAVE_TRIANGLE)),
        cfg_row(CFG_GAIN, 17'd65536),
        // write to a missing register must change nothing
        cfg_row(CFG_UNUSED, 17'd3),
        seen_row(12'd4095, 8'd0, 1'b0),
        cfg_row(CFG_PERIOD, 17'h1FFFF),
        tick_row(1'b1), tick_row(1'b1),
        cfg_row(CFG_PERIOD, 17'h10001),
        tick_row(1'b1), tick_row(1'b1), tick_row(1'b1),
        cfg_row(CFG_WAVE_SEL, CFG_DATA_W'(WAVE_SINE))
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic no_idle = 1'b0;
    int   errors = 0;
    int   ticks_sent = 0;

    // timer and table model
    logic [SAMPLE_W-1:0]  wave_sine [TABLE_SIZE];
    t_wave                model_wave;
    logic [GAIN_W-1:0]    model_gain;
    logic [PERIOD_W-1:0]  model_period;
    logic [PERIOD_W-1:0]  model_ticks;
    logic [TABLE_AW-1:0]  model_pos;
    t_sample_exp          pending_samples [$];

    twg_in_if  tick_if ();
    twg_out_if sample_if ();
    twg_cfg_if cfg_if ();

    table_waveform_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .i_cfg   (cfg_if),
        .o_out   (sample_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [SAMPLE_W-1:0] sine_entry(int pos);
        longint unsigned n;
        longint unsigned p;
        longint unsigned a;
        longint unsigned x;
        longint unsigned term;
        longint unsigned s;
        logic            lower;
        n     = TABLE_SIZE;
        p     = 4 * longint'(pos);
        lower = (p > 2 * n);
        // fold the angle into the first quadrant
        if (p <= n) begin
            a = p;
        end else if (p <= 2 * n) begin
            a = 2 * n - p;
        end else if (p <= 3 * n) begin
            a = p - 2 * n;
        end else begin
            a = 4 * n - p;
        end
        if (a == 0) begin
            s = 0;
        end else if (a >= n) begin
            s = Q30_UNIT;
        end else begin
            x    = (QUARTER_TURN_Q30 * a) / n;
            term = x;
            s    = x;
            for (int k = 1; k <= 8; k++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    s = (s >= term) ? s - term : 64'd0;
                end else begin
                    s = s + term;
                end
            end
            if (s > Q30_UNIT) begin
                s = Q30_UNIT;
            end
        end
        return SAMPLE_W'((longint'(FULL_SCALE) * (lower ? Q30_UNIT - s : Q30_UNIT + s)) >> 31);
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WAVE_SEL: model_wave   = t_wave'(data[1:0]);
            CFG_GAIN:     model_gain   = data[GAIN_W-1:0];
            CFG_PERIOD:   model_period = data[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic advance_timer(input logic run, output logic emit, output t_sample_exp res);
        longint unsigned base;
        longint unsigned scaled;
        longint unsigned p;
        longint unsigned n;
        longint unsigned f;
        emit = 1'b0;
        res  = '0;
        p    = model_pos;
        n    = TABLE_SIZE;
        f    = FULL_SCALE;
        if (!run) begin
            model_ticks = '0;
            model_pos   = '0;
        end else if (model_ticks < model_period) begin
            model_ticks = model_ticks + 1'b1;
        end else begin
            model_ticks = '0;
            case (model_wave)
                WAVE_SINE:     base = wave_sine[model_pos];
                WAVE_SQUARE:   base = (p < n / 2) ? f : 64'd0;
                WAVE_TRIANGLE: base = (f * ((2 * p >= n) ? 2 * p - n : n - 2 * p)) / n;
                default:       base = (f * p) / n;
            endcase
            scaled = (base * model_gain) >> GAIN_FRAC;
            if (scaled > SAMPLE_MAX) begin
                scaled = SAMPLE_MAX;
            end
            res.sample  = scaled[SAMPLE_W-1:0];
            res.phase   = PHASE_W'(model_pos);
            res.cyc_end = (p == n - 1);
            model_pos   = model_pos + 1'b1;
            emit        = 1'b1;
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    // ready is sampled on the falling edge, where every input is settled
    task automatic send_tick(input logic run, input logic typed, input t_sample_exp seen);
        logic        got_ready;
        logic        emit;
        t_sample_exp res;
        while (!no_idle && $urandom_range(0, 99) < 7) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.run   <= run;
        do begin
            @(negedge i_clk);
            got_ready = tick_if.ready;
            if (got_ready) begin
                advance_timer(run, emit, res);
                if (emit) begin
                    pending_samples.push_back(typed ? seen : res);
                end
            end
            @(posedge i_clk);
        end while (!got_ready);
        ticks_sent++;
    endtask

    // no register write while a tick may still be in flight
    task automatic settle();
        tick_if.valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        logic got_ready;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do begin
            @(negedge i_clk);
            got_ready = cfg_if.ready;
            if (got_ready) begin
                apply_write(idx, data);
            end
            @(posedge i_clk);
        end while (!got_ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        sample_if.ready <= no_idle || ($urandom_range(0, 99) >= 7);
    end

    always @(negedge i_clk) begin : check_samples
        t_sample_exp want;
        if (i_rst_n && sample_if.valid && sample_if.ready) begin
            if (pending_samples.size() == 0) begin
                report("unexpected sample transfer", sample_if.sample, -1);
            end else begin
                want = pending_samples.pop_front();
                if (sample_if.sample !== want.sample) begin
                    report("sample", sample_if.sample, want.sample);
                end
                if (sample_if.phase_index !== want.phase) begin
                    report("phase_index", sample_if.phase_index, want.phase);
                end
                if (sample_if.cycle_end !== want.cyc_end) begin
                    report("cycle_end", sample_if.cycle_end, want.cyc_end);
                end
            end
        end
    end

    initial begin
        t_sample_exp          none;
        t_sample_exp          seen;
        logic [CFG_DATA_W-1:0] v;
        int                   phase_no;
        int                   len;
        int                   pick;
        logic                 noisy;
        logic                 force_period;

        tick_if.valid   = 1'b0;
        tick_if.run     = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_WAVE_SEL;
        cfg_if.data     = '0;
        sample_if.ready = 1'b0;
        i_rst_n         = 1'b0;

        none = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            wave_sine[i] = sine_entry(i);
        end
        model_wave   = WAVE_SINE;
        model_gain   = 17'd65536;
        model_period = 16'd999;
        model_ticks  = '0;
        model_pos    = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                settle();
                cfg_write(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            end else begin
                seen.sample  = DIR_ROWS[r].sample;
                seen.phase   = DIR_ROWS[r].phase;
                seen.cyc_end = DIR_ROWS[r].cyc_end;
                send_tick(DIR_ROWS[r].run, DIR_ROWS[r].typed, seen);
            end
        end

        ticks_sent   = 0;
        phase_no     = 0;
        force_period = 1'b0;
        while (ticks_sent < TICK_TARGET) begin
            settle();
            no_idle = (phase_no >= QUIET_FIRST && phase_no <= QUIET_LAST);
            if ($urandom_range(0, 9) < 6) begin
                cfg_write(CFG_WAVE_SEL, CFG_DATA_W'($urandom()));
            end
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 9))
                    0:       v = 17'd0;
                    1, 2:    v = 17'd65536;
                    3:       v = 17'h1FFFF;
                    default: v = CFG_DATA_W'($urandom());
                endcase
                cfg_write(CFG_GAIN, v);
            end
            len = $urandom_range(20, 160);
            if (force_period || $urandom_range(0, 9) < 6) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    v[15:0] = 16'd0;
                end else if (pick < 75) begin
                    v[15:0] = 16'($urandom_range(1, 3));
                end else if (pick < 90) begin
                    v[15:0] = 16'($urandom_range(4, 30));
                end else if (pick < 95 && !force_period) begin
                    v[15:0] = 16'hFFFF;
                end else begin
                    v[15:0] = 16'($urandom_range(100, 400));
                end
                v[16]        = 1'($urandom_range(0, 1));
                // a parked timer is cut short and lowered in the next phase
                force_period = (v[15:0] == 16'hFFFF);
                if (force_period) begin
                    len = $urandom_range(20, 60);
                end
                cfg_write(CFG_PERIOD, v);
            end
            if ($urandom_range(0, 9) == 0) begin
                cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom()));
            end
            noisy = ($urandom_range(0, 3) == 0);
            for (int t = 0; t < len; t++) begin
                send_tick(noisy ? ($urandom_range(0, 99) >= 3) : 1'b1, 1'b0, none);
            end
            phase_no++;
        end
        no_idle = 1'b0;

        tick_if.valid <= 1'b0;
        for (int w = 0; w < 2000 && pending_samples.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (pending_samples.size() != 0) begin
            report("samples never transferred", 0, pending_samples.size());
        end
        if (errors == 0) begin
            $display("[table_waveform_generator] OK");
        end else begin
            $display("[table_waveform_generator] ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("[table_waveform_generator] ERROR");
        $finish;
    end

endmodule
